FILE: sv/sli_pkg.sv
package sli_pkg;

  // Number of cells in the chain
  localparam int unsigned CAPACITY = 16;
  // Width of the internal fill count, wide enough to hold CAPACITY itself
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_e;

  typedef struct packed {
    logic                      op;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [COUNT_W-1:0]   entry_count;
  } rsp_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic                      cmp_en;
    logic                      upd_en;
    logic                      op;
    logic signed [VALUE_W-1:0] value;
    logic                      found;
    logic                      full;
  } cell_ctl_t;

endpackage

FILE: sv/sorted_list_insert_delete.sv
// Channel   Direction  Payload  Handshake
// in        request    req_t    in_valid_i / in_stall_o
// out       response   rsp_t    out_valid_o / out_stall_i
//
// Each request passes through three steps: accept, compare in every cell at once,
// then shift the chain by one place and load the response register.
// The compare step registers the cell flags that the shift step then uses.
// Reset empties the list by clearing the fill count; cell contents are not reset.
// A stalled response holds the shift step; the next request is taken while
// a response waits.
module sorted_list_insert_delete (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sli_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sli_pkg::rsp_t out_rsp_o
);
  import sli_pkg::*;

  state_e             state_q, state_d;
  req_t               req_q;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic               out_valid_q, out_valid_d;
  rsp_t               rsp_q, rsp_d;

  cell_ctl_t          ctl;
  logic               slot_free;
  logic               in_accept;
  logic               found;
  logic               full;

  logic signed [VALUE_W-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0]       valid;
  logic [CAPACITY-1:0]       le;
  logic [CAPACITY-1:0]       eq;

  assign in_accept = in_valid_i && !in_stall_o;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign found     = |eq;
  assign full      = (fill_q == CNT_W'(CAPACITY));

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_CMP;
      S_CMP:   state_d = S_APPLY;
      S_APPLY: if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Drive the cell controls and the request side
  always_comb begin
    ctl.cmp_en = 1'b0;
    ctl.upd_en = 1'b0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE:  in_stall_o = 1'b0;
      S_CMP:   ctl.cmp_en = 1'b1;
      S_APPLY: ctl.upd_en = slot_free;
      default: in_stall_o = 1'b1;
    endcase
    ctl.op    = req_q.op;
    ctl.value = req_q.value;
    ctl.found = found;
    ctl.full  = full;
  end

  // Build the response and the new fill count
  always_comb begin
    fill_d = fill_q;
    rsp_d  = rsp_q;
    if (ctl.upd_en) begin
      if (req_q.op == OP_INSERT) begin
        if (full) begin
          rsp_d.status = ST_FULL;
        end else begin
          rsp_d.status = ST_OK;
          fill_d       = fill_q + CNT_W'(1);
        end
      end else begin
        if (found) begin
          rsp_d.status = ST_OK;
          fill_d       = fill_q - CNT_W'(1);
        end else begin
          rsp_d.status = ST_NOT_FOUND;
        end
      end
      rsp_d.entry_count = COUNT_W'(fill_d);
    end
  end

  // Load or drop the response
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl.upd_en) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the request and the response payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_req_i;
    end
    rsp_q <= rsp_d;
  end

  // Chain of cells, one entry each
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic                      left_le;
    logic signed [VALUE_W-1:0] left_entry;
    logic signed [VALUE_W-1:0] right_entry;

    assign valid[i] = (fill_q > IDX);

    if (i == 0) begin : g_head
      assign left_le    = 1'b1;
      assign left_entry = req_q.value;
    end else begin : g_body
      assign left_le    = le[i-1];
      assign left_entry = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = entry[i];
    end else begin : g_mid
      assign right_entry = entry[i+1];
    end

    sli_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .valid_i      (valid[i]),
      .left_le_i    (left_le),
      .left_entry_i (left_entry),
      .right_entry_i(right_entry),
      .entry_o      (entry[i]),
      .le_o         (le[i]),
      .eq_o         (eq[i])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // The fill count never passes the chain length
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // An accepted request moves on to the compare step
  a_accept_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_CMP))
    else $error("accepted request did not reach compare");

  // The shift step always leaves a response behind
  a_apply_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.upd_en |=> out_valid_q)
    else $error("shift step without response");

  // The fill count moves only on a shift step
  a_fill_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl.upd_en |=> $stable(fill_q))
    else $error("fill count changed outside shift step");

endmodule

FILE: sv/sli_cell.sv
module sli_cell (
  input  logic                               clk_i,
  input  sli_pkg::cell_ctl_t                 ctl_i,
  input  logic                               valid_i,
  input  logic                               left_le_i,
  input  logic signed [sli_pkg::VALUE_W-1:0] left_entry_i,
  input  logic signed [sli_pkg::VALUE_W-1:0] right_entry_i,
  output logic signed [sli_pkg::VALUE_W-1:0] entry_o,
  output logic                               le_o,
  output logic                               eq_o
);
  import sli_pkg::*;

  logic signed [VALUE_W-1:0] entry_q, entry_d;
  logic                      le_q, lt_q, eq_q;

  // Compare the held entry against the request value
  always_ff @(posedge clk_i) begin
    if (ctl_i.cmp_en) begin
      le_q <= valid_i && (entry_q <= ctl_i.value);
      lt_q <= valid_i && (entry_q <  ctl_i.value);
      eq_q <= valid_i && (entry_q == ctl_i.value);
    end
  end

  // Hold, take the new value, or take a neighbor's entry
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.upd_en) begin
      if (ctl_i.op == OP_INSERT) begin
        if (!ctl_i.full && !le_q) begin
          entry_d = left_le_i ? ctl_i.value : left_entry_i;
        end
      end else begin
        if (ctl_i.found && !lt_q) begin
          entry_d = right_entry_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign le_o    = le_q;
  assign eq_o    = eq_q;

endmodule

FILE: sim/tb_sorted_list_insert_delete.sv
`timescale 1ns / 100ps

module tb_sorted_list_insert_delete;
  import sli_pkg::*;

  localparam int unsigned MAX_CYCLES = 600000;
  localparam int unsigned RANDOM_REQS = 1250;
  localparam int unsigned LONG_HOLD = 160;
  localparam int unsigned DRAIN_CYCLES = 12;

  typedef struct {
    req_t req;
    bit   drain;
  } pend_req_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_rsp_o;

  sorted_list_insert_delete u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  // Shadow of the list contents, ascending
  logic signed [VALUE_W-1:0] shadow_list[$];
  rsp_t                      rsp_expect_q[$];
  pend_req_t                 pending_q[$];

  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned req_accepted = 0;
  bit          req_taken = 1'b0;
  bit          rsp_taken = 1'b0;

  // Apply one request to the shadow list and return the response it must produce
  function automatic rsp_t apply_request(req_t r);
    logic signed [VALUE_W-1:0] v = r.value;
    int unsigned               pos = 0;
    rsp_t                      rsp;
    rsp.status = ST_OK;
    if (r.op == OP_INSERT) begin
      if (shadow_list.size() >= CAPACITY) begin
        rsp.status = ST_FULL;
      end else begin
        while (pos < shadow_list.size() && shadow_list[pos] <= v) pos++;
        shadow_list.insert(pos, v);
      end
    end else begin
      while (pos < shadow_list.size() && shadow_list[pos] != v) pos++;
      if (pos >= shadow_list.size()) rsp.status = ST_NOT_FOUND;
      else shadow_list.delete(pos);
    end
    rsp.entry_count = COUNT_W'(shadow_list.size());
    return rsp;
  endfunction

  // Draw an idle count; now and then run a burst with no idling at all
  function automatic int unsigned pick_wait(inout int unsigned quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 30) == 0) quiet_left = $urandom_range(20, 60);
    return $urandom_range(0, 18);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  task automatic add_req(input logic op, input logic [VALUE_W-1:0] value, input bit drain);
    pend_req_t p;
    p.req.op    = op;
    p.req.value = value;
    p.drain     = drain;
    pending_q.push_back(p);
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // Monitor: check responses, then predict for each accepted request
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      rsp_taken = 1'b1;
      if (rsp_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected response status=%0d count=%0d",
                                  out_rsp_o.status, out_rsp_o.entry_count));
      end else begin
        want = rsp_expect_q.pop_front();
        if (out_rsp_o.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_rsp_o.status, want.status));
        if (out_rsp_o.entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count got %0d want %0d",
                                    out_rsp_o.entry_count, want.entry_count));
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      req_taken = 1'b1;
      req_accepted++;
      rsp_expect_q.push_back(apply_request(in_req_i));
    end
  end

  // Request driver: hold each request until taken, idle between requests
  int unsigned tx_wait = 0;
  int unsigned tx_quiet = 0;
  bit          tx_busy = 1'b0;
  pend_req_t   tx_cur;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_taken) begin
        req_taken = 1'b0;
        tx_busy   = 1'b0;
        tx_wait   = pick_wait(tx_quiet);
      end
      if (!tx_busy) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (pending_q.size() > 0 &&
                     !(pending_q[0].drain && rsp_expect_q.size() > 0)) begin
          tx_cur  = pending_q.pop_front();
          tx_busy = 1'b1;
        end
      end
      in_valid_i <= tx_busy;
      in_req_i   <= tx_cur.req;
    end
  end

  // Response side: random stalls per response, plus two long holds
  int unsigned rx_wait = 0;
  int unsigned rx_quiet = 0;
  int unsigned rx_hold = 0;
  int unsigned hold_idx = 0;
  int unsigned hold_at[2] = '{300, 900};

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rsp_taken) begin
        rsp_taken = 1'b0;
        rx_wait   = pick_wait(rx_quiet);
      end
      if (hold_idx < 2 && req_accepted >= hold_at[hold_idx]) begin
        hold_idx++;
        rx_hold = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall_i <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic signed [VALUE_W-1:0] pool[8];
    int unsigned               made;
    int unsigned               phase_len;
    int unsigned               ins_pct;
    logic                      op;
    logic [VALUE_W-1:0]        value;

    // Directed: empty delete, extremes, duplicates, absent value, full list
    add_req(OP_DELETE, 32'd0, 1'b0);
    add_req(OP_INSERT, 32'h7FFF_FFFF, 1'b0);
    add_req(OP_INSERT, 32'h8000_0000, 1'b0);
    add_req(OP_INSERT, 32'd0, 1'b0);
    add_req(OP_INSERT, 32'hFFFF_FFFF, 1'b0);
    add_req(OP_INSERT, 32'd1, 1'b0);
    repeat (3) add_req(OP_INSERT, 32'd5, 1'b0);
    add_req(OP_DELETE, 32'd5, 1'b0);
    add_req(OP_DELETE, 32'd7, 1'b0);
    add_req(OP_INSERT, 32'hAAAA_AAAA, 1'b0);
    add_req(OP_INSERT, 32'h5555_5555, 1'b0);
    repeat (7) add_req(OP_INSERT, $urandom(), 1'b0);
    add_req(OP_INSERT, 32'd3, 1'b0);
    add_req(OP_DELETE, 32'h7FFF_FFFF, 1'b0);
    add_req(OP_DELETE, 32'h8000_0000, 1'b0);
    add_req(OP_DELETE, 32'h8000_0000, 1'b0);

    // Random phases: each with its own insert bias and a small value pool
    made = 0;
    while (made < RANDOM_REQS) begin
      phase_len = $urandom_range(60, 150);
      case ($urandom_range(0, 2))
        0: ins_pct = 85;
        1: ins_pct = 50;
        default: ins_pct = 15;
      endcase
      foreach (pool[k]) begin
        case ($urandom_range(0, 5))
          0: pool[k] = 32'h7FFF_FFFF;
          1: pool[k] = 32'h8000_0000;
          2: pool[k] = $urandom();
          default: pool[k] = $signed(32'($urandom_range(0, 12))) - 6;
        endcase
      end
      for (int unsigned n = 0; n < phase_len; n++) begin
        op    = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_DELETE;
        value = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 7)] : $urandom();
        add_req(op, value, n == 0);
      end
      made += phase_len;
    end

    // Reset
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for the last request, then for every response, then let it settle
    while (pending_q.size() > 0 || tx_busy) @(posedge clk_i);
    while (rsp_expect_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/sli_pkg.sv
sv/sli_cell.sv
sv/sorted_list_insert_delete.sv
sim/tb_sorted_list_insert_delete.sv
